// ===== sv/vpcr_pkg.sv =====
// shared types and codes for the vector path command resolver
// no dependencies; imported by every module of the block
package vpcr_pkg;

  // default coordinate width, Q16.16 in 32 bits
  localparam int COORD_WIDTH_DEF = 32;

  // command codes
  localparam logic [3:0] CMD_MOVE        = 4'd0;
  localparam logic [3:0] CMD_LINE        = 4'd1;
  localparam logic [3:0] CMD_HORIZ       = 4'd2;
  localparam logic [3:0] CMD_VERT        = 4'd3;
  localparam logic [3:0] CMD_CUBIC       = 4'd4;
  localparam logic [3:0] CMD_SMOOTH_CUBIC = 4'd5;
  localparam logic [3:0] CMD_QUAD        = 4'd6;
  localparam logic [3:0] CMD_SMOOTH_QUAD = 4'd7;
  localparam logic [3:0] CMD_CLOSE       = 4'd8;
  localparam logic [3:0] CMD_ARC         = 4'd9;
  localparam logic [3:0] CMD_UNKNOWN     = 4'd10;

  // segment kinds on the result
  localparam logic [1:0] SEG_LINE  = 2'd0;
  localparam logic [1:0] SEG_QUAD  = 2'd1;
  localparam logic [1:0] SEG_CUBIC = 2'd2;
  localparam logic [1:0] SEG_UNSUP = 2'd3;

  // kind of the last curve, for smooth reflection
  localparam logic [1:0] CURVE_NONE  = 2'd0;
  localparam logic [1:0] CURVE_QUAD  = 2'd1;
  localparam logic [1:0] CURVE_CUBIC = 2'd2;

  // one path command
  typedef struct packed {
    logic [3:0]         cmd;
    logic               relative;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
  } in_item_t;

  // one absolute segment
  typedef struct packed {
    logic [1:0]         seg_kind;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] ctrl1_x;
    logic signed [31:0] ctrl1_y;
    logic signed [31:0] ctrl2_x;
    logic signed [31:0] ctrl2_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
  } seg_t;

endpackage

// ===== sv/vpcr_in_stage.sv =====
// input register of the resolver: holds one command until the core consumes it
// depends on vpcr_pkg
module vpcr_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  vpcr_pkg::in_item_t s_item,
  input  logic               adv,
  output logic               item_valid,
  output vpcr_pkg::in_item_t item
);
  import vpcr_pkg::*;

  // free slot or the held command leaves this cycle
  assign s_tready = !item_valid || adv;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

// ===== sv/vpcr_core.sv =====
// path state and single-pass segment resolution: relative offset, saturation,
// smooth reflection and pen/subpath update; depends on vpcr_pkg
module vpcr_core #(
  parameter int COORD_WIDTH = vpcr_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vpcr_pkg::in_item_t item,
  input  logic               adv,
  output vpcr_pkg::seg_t     seg,
  output logic               has_result
);
  import vpcr_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int XW = (CW > 32) ? CW : 32;
  localparam logic signed [XW-1:0] CMAX_X = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN_X = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] coord_t;

  // 32-bit input into the coordinate range
  function automatic coord_t read_coord(input logic signed [31:0] v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    if (w > CMAX_X) return CMAX;
    if (w < CMIN_X) return CMIN;
    return w[CW-1:0];
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
    return s[CW-1:0];
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) - (CW+1)'(b);
    if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
    return s[CW-1:0];
  endfunction

  // low 32 bits of the sign-extended coordinate
  function automatic logic [31:0] to_out(input coord_t v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    return w[31:0];
  endfunction

  // path state
  coord_t     pen_x, pen_y, subpath_x, subpath_y, last_ctrl_x, last_ctrl_y;
  logic [1:0] last_curve_kind;

  coord_t     ox, oy;
  coord_t     ax1, ay1, ax2, ay2, ax3, ay3;
  coord_t     refl_x, refl_y;
  coord_t     c1x, c1y, c2x, c2y, tx, ty;
  coord_t     last_ctrl_x_next, last_ctrl_y_next;
  logic [1:0] kind, curve_kind_next;
  logic       is_move;

  // absolute coordinates
  always_comb begin
    ox  = item.relative ? pen_x : '0;
    oy  = item.relative ? pen_y : '0;
    ax1 = sat_add(read_coord(item.p1_x), ox);
    ay1 = sat_add(read_coord(item.p1_y), oy);
    ax2 = sat_add(read_coord(item.p2_x), ox);
    ay2 = sat_add(read_coord(item.p2_y), oy);
    ax3 = sat_add(read_coord(item.p3_x), ox);
    ay3 = sat_add(read_coord(item.p3_y), oy);
  end

  // reflection of the last control point about the pen
  always_comb begin
    refl_x = sat_add(pen_x, sat_sub(pen_x, last_ctrl_x));
    refl_y = sat_add(pen_y, sat_sub(pen_y, last_ctrl_y));
  end

  // command decode
  always_comb begin
    kind             = SEG_LINE;
    c1x              = '0;
    c1y              = '0;
    c2x              = '0;
    c2y              = '0;
    tx               = pen_x;
    ty               = pen_y;
    curve_kind_next  = CURVE_NONE;
    last_ctrl_x_next = last_ctrl_x;
    last_ctrl_y_next = last_ctrl_y;
    is_move          = 1'b0;
    unique case (item.cmd)
      CMD_MOVE: begin
        is_move = 1'b1;
        tx      = ax1;
        ty      = ay1;
      end
      CMD_LINE: begin
        tx = ax1;
        ty = ay1;
      end
      CMD_HORIZ: begin
        tx = ax1;
      end
      CMD_VERT: begin
        ty = ay1;
      end
      CMD_CUBIC: begin
        kind             = SEG_CUBIC;
        c1x              = ax1;
        c1y              = ay1;
        c2x              = ax2;
        c2y              = ay2;
        tx               = ax3;
        ty               = ay3;
        last_ctrl_x_next = ax2;
        last_ctrl_y_next = ay2;
        curve_kind_next  = CURVE_CUBIC;
      end
      CMD_SMOOTH_CUBIC: begin
        kind             = SEG_CUBIC;
        c1x              = (last_curve_kind == CURVE_CUBIC) ? refl_x : pen_x;
        c1y              = (last_curve_kind == CURVE_CUBIC) ? refl_y : pen_y;
        c2x              = ax1;
        c2y              = ay1;
        tx               = ax2;
        ty               = ay2;
        last_ctrl_x_next = ax1;
        last_ctrl_y_next = ay1;
        curve_kind_next  = CURVE_CUBIC;
      end
      CMD_QUAD: begin
        kind             = SEG_QUAD;
        c1x              = ax1;
        c1y              = ay1;
        tx               = ax2;
        ty               = ay2;
        last_ctrl_x_next = ax1;
        last_ctrl_y_next = ay1;
        curve_kind_next  = CURVE_QUAD;
      end
      CMD_SMOOTH_QUAD: begin
        kind             = SEG_QUAD;
        c1x              = (last_curve_kind == CURVE_QUAD) ? refl_x : pen_x;
        c1y              = (last_curve_kind == CURVE_QUAD) ? refl_y : pen_y;
        tx               = ax1;
        ty               = ay1;
        last_ctrl_x_next = c1x;
        last_ctrl_y_next = c1y;
        curve_kind_next  = CURVE_QUAD;
      end
      CMD_CLOSE: begin
        tx = subpath_x;
        ty = subpath_y;
      end
      default: begin
        // arc, unknown and unused codes
        kind = SEG_UNSUP;
      end
    endcase
  end

  // result for the output register
  assign has_result   = !is_move;
  assign seg.seg_kind = kind;
  assign seg.from_x   = to_out(pen_x);
  assign seg.from_y   = to_out(pen_y);
  assign seg.ctrl1_x  = to_out(c1x);
  assign seg.ctrl1_y  = to_out(c1y);
  assign seg.ctrl2_x  = to_out(c2x);
  assign seg.ctrl2_y  = to_out(c2y);
  assign seg.to_x     = to_out(tx);
  assign seg.to_y     = to_out(ty);

  // state update when a command is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x           <= '0;
      pen_y           <= '0;
      subpath_x       <= '0;
      subpath_y       <= '0;
      last_ctrl_x     <= '0;
      last_ctrl_y     <= '0;
      last_curve_kind <= CURVE_NONE;
    end else if (adv) begin
      pen_x           <= tx;
      pen_y           <= ty;
      last_ctrl_x     <= last_ctrl_x_next;
      last_ctrl_y     <= last_ctrl_y_next;
      last_curve_kind <= curve_kind_next;
      if (is_move) begin
        subpath_x <= tx;
        subpath_y <= ty;
      end
    end
  end

`ifndef SYNTHESIS
  // a move leaves pen and subpath start on the same point
  a_move_sets_subpath: assert property (@(posedge clk) disable iff (rst)
    adv && item.cmd == CMD_MOVE |=> pen_x == subpath_x && pen_y == subpath_y)
    else $error("move did not align pen and subpath start");

  // only curves leave a curve kind behind
  a_kind_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && item.cmd != CMD_CUBIC && item.cmd != CMD_SMOOTH_CUBIC &&
    item.cmd != CMD_QUAD && item.cmd != CMD_SMOOTH_QUAD
    |=> last_curve_kind == CURVE_NONE)
    else $error("curve kind kept after a non-curve command");

  // unsupported commands leave the pen where it was
  a_unsup_holds_pen: assert property (@(posedge clk) disable iff (rst)
    adv && kind == SEG_UNSUP |=> $stable(pen_x) && $stable(pen_y))
    else $error("pen moved on an unsupported command");
`endif

endmodule

// ===== sv/vpcr_out_stage.sv =====
// result register of the resolver: holds one segment until the sink takes it
// depends on vpcr_pkg
module vpcr_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  vpcr_pkg::seg_t seg_in,
  output logic           can_load,
  output logic           m_tvalid,
  input  logic           m_tready,
  output vpcr_pkg::seg_t seg
);
  import vpcr_pkg::*;

  // empty or emptied this cycle
  assign can_load = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      seg <= seg_in;
    end
  end

endmodule

// ===== sv/vector_path_command_resolver_top.sv =====
// top level of the vector path command resolver: input register, core, result register
// depends on vpcr_pkg, vpcr_in_stage, vpcr_core, vpcr_out_stage
//
//  channel  dir  tdata                           tuser
//  s_*      in   p1_x .. p3_y, 192 bits          cmd[3:0], relative[4]
//  m_*      out  from_x .. to_y, 256 bits        seg_kind[1:0]
//
// one command per cycle sustained while m_tready is high; a command's segment raises m_tvalid
// after its transfer on s_*, passing through the input register and then the result register
// a move updates the state and produces no transfer on m_*
// rst is synchronous and clears the path state (pen, subpath, last control, curve kind)
// a stall on m_tready holds the result and, once the input register is full, s_tready
module vector_path_command_resolver_top #(
  parameter int COORD_WIDTH = vpcr_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  logic [4:0]   s_tuser,  // cmd[3:0], relative
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,  // from_x, from_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, to_x, to_y
  output logic [1:0]   m_tuser   // seg_kind
);
  import vpcr_pkg::*;

  in_item_t s_item, item;
  seg_t     seg_core, seg_out;
  logic     item_valid, adv, has_result, can_load;

  // unpack the input transfer
  always_comb begin
    s_item.cmd      = s_tuser[3:0];
    s_item.relative = s_tuser[4];
    s_item.p1_x     = s_tdata[31:0];
    s_item.p1_y     = s_tdata[63:32];
    s_item.p2_x     = s_tdata[95:64];
    s_item.p2_y     = s_tdata[127:96];
    s_item.p3_x     = s_tdata[159:128];
    s_item.p3_y     = s_tdata[191:160];
  end

  // a held command moves on when its result has room, or it has no result
  assign adv = item_valid && (!has_result || can_load);

  vpcr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  vpcr_core #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .adv        (adv),
    .seg        (seg_core),
    .has_result (has_result)
  );

  vpcr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv && has_result),
    .seg_in   (seg_core),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .seg      (seg_out)
  );

  // pack the result transfer
  assign m_tuser = seg_out.seg_kind;
  assign m_tdata = {seg_out.to_y, seg_out.to_x, seg_out.ctrl2_y, seg_out.ctrl2_x,
                    seg_out.ctrl1_y, seg_out.ctrl1_x, seg_out.from_y, seg_out.from_x};

endmodule
